// ----- rtl/lcs_pkg.sv -----
// Types and constants shared by the line centroid steering block.
package lcs_pkg;

	localparam int unsigned FW_W     = 11;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned SPEED_W  = 16;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned REG_IDX_W = 2;

	localparam int unsigned TOT_W    = 21;
	localparam int unsigned SUM_W    = 30;
	localparam int unsigned FRAC_W   = 8;
	localparam int unsigned QUOT_W   = SUM_W + FRAC_W + 1;
	localparam int unsigned REM_W    = TOT_W + 1;
	localparam int unsigned DIFF_W   = QUOT_W + 1;
	localparam int unsigned DIV_CNT_W = $clog2(QUOT_W + 1);

	localparam int unsigned ERR_W    = 20;
	localparam int unsigned MAG_W    = ERR_W - 1;
	localparam int unsigned PROD_W   = MAG_W + GAIN_W;
	localparam int unsigned RATE_W   = 28;

	localparam int unsigned GREY_W     = 8;
	localparam int unsigned GREY_ACC_W = 22;
	localparam int unsigned GREY_SHIFT = 14;

	localparam logic [GREY_ACC_W-1:0] GREY_R    = 22'd4899;
	localparam logic [GREY_ACC_W-1:0] GREY_G    = 22'd9617;
	localparam logic [GREY_ACC_W-1:0] GREY_B    = 22'd1868;
	localparam logic [GREY_ACC_W-1:0] GREY_HALF = 22'd8192;

	localparam logic [TOT_W-1:0] TOT_CAP = '1;
	localparam logic [SUM_W-1:0] SUM_CAP = '1;

	localparam logic signed [DIFF_W-1:0] ERR_HI = 40'sd262144;
	localparam logic signed [DIFF_W-1:0] ERR_LO = -40'sd262144;
	localparam logic [RATE_W-1:0] RATE_CAP = 28'd67108864;
	localparam logic [PROD_W:0] ROUND_HALF = 36'd128;

	localparam logic [FW_W-1:0]    FW_RESET    = 11'd640;
	localparam logic [THR_W-1:0]   THR_RESET   = 8'd100;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd13107;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd655;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_DARK_THRESHOLD = 2'd1,
		REG_FORWARD_SPEED  = 2'd2,
		REG_STEER_GAIN     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_PIXEL,
		ST_DIVIDE,
		ST_SCALE,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} pix_t;

	typedef struct packed {
		logic                      line_found;
		logic [SPEED_W-1:0]        linear_speed;
		logic signed [RATE_W-1:0]  angular_rate;
		logic signed [ERR_W-1:0]   centre_error;
	} res_t;

endpackage

// ----- rtl/lcs_if.sv -----
// Valid/ready channels for pixels and steering results.
interface lcs_pix_if import lcs_pkg::*;;
	logic valid;
	logic ready;
	pix_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcs_res_if import lcs_pkg::*;;
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lcs_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
module lcs_div import lcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QUOT_W-1:0] dividend,
	input  logic [TOT_W-1:0]  divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [REM_W-2:0]     rem_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [TOT_W-1:0]     div_q;

	logic [REM_W-1:0]     rem_sh;
	logic                 fits;
	logic [REM_W-1:0]     rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quot_q[QUOT_W-1]};
		fits    = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub[REM_W-2:0] : rem_sh[REM_W-2:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- rtl/line_centroid_steering_top.sv -----
// Line centroid steering: pixel accumulation, centroid divide and steering output.
// Sequence: a pixel without frame_end is accumulated as it is taken; a frame_end transaction
// with line pixels runs the shift-subtract divider, then clamp, gain multiply, rounding and
// the output register; without line pixels it goes straight to the output register.
// Throughput: 1 pixel per cycle while in the pixel state; input is stalled from a frame end
// until its result is loaded, and longer while an earlier result waits on res.ready.
// Reset: arst_n clears accumulators, sequencer and output valid; registers take defaults.
module line_centroid_steering_top import lcs_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	lcs_pix_if.sink               pix,
	lcs_res_if.source             res
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned MW_W  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CMP_W = (MW_W > FW_W) ? MW_W : FW_W;

	logic [FW_W-1:0]    frame_width_q;
	logic [THR_W-1:0]   dark_threshold_q;
	logic [SPEED_W-1:0] forward_speed_q;
	logic [GAIN_W-1:0]  steer_gain_q;

	logic [COL_W-1:0]   col_q;
	logic [TOT_W-1:0]   tot_q;
	logic [SUM_W-1:0]   sum_q;

	state_t state_q, state_d;

	logic                      found_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [PROD_W-1:0]         prod_q;
	logic signed [RATE_W-1:0]  rate_q;
	logic                      res_valid_q;
	res_t                      res_q;

	logic [FW_W-1:0]       eff_w;
	logic [COL_W-1:0]      col;
	logic [COL_W-1:0]      col_next;
	logic [GREY_ACC_W-1:0] grey_acc;
	logic [GREY_W-1:0]     grey;
	logic                  line_px;
	logic [TOT_W-1:0]      tot_next;
	logic [SUM_W:0]        sum_wide;
	logic [SUM_W-1:0]      sum_next;
	logic [QUOT_W-1:0]     dividend;
	logic                  pix_accept;
	logic                  div_start;
	logic                  div_done;
	logic [QUOT_W-1:0]     quotient;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ERR_W-1:0]  err_clamped;
	logic [MAG_W-1:0]      err_mag;
	logic [PROD_W:0]       prod_rnd;
	logic [RATE_W-1:0]     rate_mag;
	logic                  out_free;
	logic                  res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FW_RESET;
			dark_threshold_q <= THR_RESET;
			forward_speed_q  <= SPEED_RESET;
			steer_gain_q     <= GAIN_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[FW_W-1:0];
				REG_DARK_THRESHOLD: dark_threshold_q <= cfg_data[THR_W-1:0];
				REG_FORWARD_SPEED:  forward_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_STEER_GAIN:     steer_gain_q     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = FW_W'(1);
		end else if (CMP_W'(frame_width_q) > CMP_W'(MAX_WIDTH)) begin
			eff_w = FW_W'(MAX_WIDTH);
		end else begin
			eff_w = frame_width_q;
		end

		col      = (CMP_W'(col_q) >= CMP_W'(eff_w)) ? '0 : col_q;
		col_next = ((CMP_W'(col) + CMP_W'(1)) >= CMP_W'(eff_w)) ? '0 : col + 1'b1;

		grey_acc = GREY_ACC_W'(pix.data.red) * GREY_R
			+ GREY_ACC_W'(pix.data.green) * GREY_G
			+ GREY_ACC_W'(pix.data.blue) * GREY_B + GREY_HALF;
		grey    = grey_acc[GREY_SHIFT +: GREY_W];
		line_px = grey <= dark_threshold_q;

		tot_next = (line_px && tot_q != TOT_CAP) ? tot_q + 1'b1 : tot_q;
		sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(col);
		if (!line_px) begin
			sum_next = sum_q;
		end else if (sum_wide[SUM_W]) begin
			sum_next = SUM_CAP;
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end

		dividend = {1'b0, sum_next, {FRAC_W{1'b0}}} + QUOT_W'(tot_next[TOT_W-1:1]);
	end

	assign pix_accept = pix.valid && pix.ready;
	assign div_start  = pix_accept && pix.data.frame_end && (tot_next != '0);
	assign out_free   = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			tot_q <= '0;
			sum_q <= '0;
		end else if (pix_accept) begin
			if (pix.data.frame_end) begin
				col_q <= '0;
				tot_q <= '0;
				sum_q <= '0;
			end else begin
				col_q <= col_next;
				tot_q <= tot_next;
				sum_q <= sum_next;
			end
		end
	end

	lcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (tot_next),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		diff = $signed({1'b0, quotient})
			- $signed(DIFF_W'({eff_w[FW_W-1:1], {FRAC_W{1'b0}}}));
		if (diff > ERR_HI) begin
			err_clamped = ERR_HI[ERR_W-1:0];
		end else if (diff < ERR_LO) begin
			err_clamped = ERR_LO[ERR_W-1:0];
		end else begin
			err_clamped = diff[ERR_W-1:0];
		end

		err_mag  = err_q[ERR_W-1] ? MAG_W'(-err_q) : MAG_W'(err_q);
		prod_rnd = {1'b0, prod_q} + ROUND_HALF;
		rate_mag = prod_rnd[FRAC_W +: RATE_W];
		if (rate_mag > RATE_CAP) begin
			rate_mag = RATE_CAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PIXEL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pix.ready = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_PIXEL: begin
				pix.ready = 1'b1;
				if (pix.valid && pix.data.frame_end) begin
					state_d = div_start ? ST_DIVIDE : ST_OUT;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_PIXEL;
				end
			end
			default: state_d = ST_PIXEL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pix_accept && pix.data.frame_end) begin
			found_q <= div_start;
			err_q   <= '0;
			rate_q  <= '0;
		end else if (state_q == ST_DIVIDE && div_done) begin
			err_q <= err_clamped;
		end else if (state_q == ST_SCALE) begin
			prod_q <= err_mag * steer_gain_q;
		end else if (state_q == ST_ROUND) begin
			rate_q <= err_q[ERR_W-1] ? $signed(rate_mag) : -$signed(rate_mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.line_found   <= found_q;
			res_q.linear_speed <= found_q ? forward_speed_q : '0;
			res_q.angular_rate <= rate_q;
			res_q.centre_error <= err_q;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

`ifndef ASSERT_OFF
	a_stall_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && pix.data.frame_end |=> !pix.ready)
		else $error("pixel taken right after a frame end transaction");

	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data.line_found |-> res.data.centre_error == '0
			&& res.data.angular_rate == '0 && res.data.linear_speed == '0)
		else $error("nonzero result without line pixels");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $signed(res.data.centre_error) <= $signed(ERR_HI[ERR_W-1:0])
			&& $signed(res.data.centre_error) >= $signed(ERR_LO[ERR_W-1:0]))
		else $error("centre error outside clamp range");

	a_steer_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.centre_error > 0 |-> res.data.angular_rate <= 0)
		else $error("steering rate has the sign of the error");
`endif

endmodule

// ----- bench/lcs_steer_checker.sv -----
`timescale 1ns / 1ps
// Checker for line centroid steering: tracks configuration and pixels, predicts results.
module lcs_steer_checker import lcs_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	lcs_pix_if                   pix,
	lcs_res_if                   res,
	output int                   fail_count,
	output int                   pending
);

	logic [FW_W-1:0]    fw_q;
	logic [THR_W-1:0]   thr_q;
	logic [SPEED_W-1:0] speed_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [9:0]         col_q;
	logic [TOT_W-1:0]   line_total_q;
	logic [SUM_W-1:0]   col_sum_q;
	res_t               steer_q[$];

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned       wid;
		int unsigned       grey;
		int unsigned       col;
		longint unsigned   acc;
		longint unsigned   cq8;
		longint unsigned   mag;
		longint            err;
		longint            rate;
		res_t              want;
		res_t              got;
		pix_t              p;
		int                errs;
		if (!arst_n) begin
			fw_q = FW_RESET;
			thr_q = THR_RESET;
			speed_q = SPEED_RESET;
			gain_q = GAIN_RESET;
			col_q = '0;
			line_total_q = '0;
			col_sum_q = '0;
			steer_q.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_FRAME_WIDTH: fw_q = cfg_data[FW_W-1:0];
					REG_DARK_THRESHOLD: thr_q = cfg_data[THR_W-1:0];
					REG_FORWARD_SPEED: speed_q = cfg_data[SPEED_W-1:0];
					REG_STEER_GAIN: gain_q = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			if (res.valid && res.ready) begin
				got = res.data;
				if (steer_q.size() == 0) begin
					$display("%0t: expected no result, actual %p", $time, got);
					errs++;
				end else begin
					want = steer_q.pop_front();
					if (got.line_found !== want.line_found) begin
						$display("%0t: line_found expected %0d actual %0d",
							$time, want.line_found, got.line_found);
						errs++;
					end
					if (got.linear_speed !== want.linear_speed) begin
						$display("%0t: linear_speed expected %0d actual %0d",
							$time, want.linear_speed, got.linear_speed);
						errs++;
					end
					if (got.angular_rate !== want.angular_rate) begin
						$display("%0t: angular_rate expected %0d actual %0d",
							$time, want.angular_rate, got.angular_rate);
						errs++;
					end
					if (got.centre_error !== want.centre_error) begin
						$display("%0t: centre_error expected %0d actual %0d",
							$time, want.centre_error, got.centre_error);
						errs++;
					end
				end
			end

			if (pix.valid && pix.ready) begin
				p = pix.data;
				wid = (fw_q == '0) ? 1 : ((fw_q > MAX_WIDTH) ? MAX_WIDTH : int'(fw_q));
				grey = (4899 * int'(p.red) + 9617 * int'(p.green) + 1868 * int'(p.blue)
					+ 8192) >> 14;
				col = col_q;
				if (col >= wid)
					col = 0;
				if (grey <= thr_q) begin
					if (line_total_q != TOT_CAP)
						line_total_q = line_total_q + 1'b1;
					acc = col_sum_q;
					acc = acc + col;
					col_sum_q = (acc > SUM_CAP) ? SUM_CAP : acc[SUM_W-1:0];
				end
				col_q = (col + 1 >= wid) ? '0 : 10'(col + 1);

				if (p.frame_end) begin
					if (line_total_q == '0) begin
						want = '0;
					end else begin
						acc = col_sum_q;
						acc = (acc << 8) + line_total_q / 2;
						cq8 = acc / line_total_q;
						err = longint'(cq8) - longint'((wid / 2) * 256);
						if (err > ERR_HI)
							err = ERR_HI;
						if (err < ERR_LO)
							err = ERR_LO;
						mag = (err < 0) ? -err : err;
						mag = (mag * gain_q + 128) >> 8;
						if (mag > RATE_CAP)
							mag = RATE_CAP;
						rate = (err < 0) ? longint'(mag) : -longint'(mag);
						want.line_found = 1'b1;
						want.linear_speed = speed_q;
						want.angular_rate = rate[RATE_W-1:0];
						want.centre_error = err[ERR_W-1:0];
					end
					steer_q.push_back(want);
					col_q = '0;
					line_total_q = '0;
					col_sum_q = '0;
				end
			end

			pending <= steer_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- bench/tb_line_centroid_steering_top.sv -----
`timescale 1ns / 1ps
// Testbench top for line centroid steering: clock, reset, pixel stimulus and verdict.
module tb_line_centroid_steering_top import lcs_pkg::*;;

	localparam int unsigned MAX_WIDTH = 1024;
	localparam int unsigned RANDOM_PIXELS = 950;
	localparam int unsigned CALM_FROM = 700;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;
	bit                   src_idle;
	bit                   snk_stall;
	logic [THR_W-1:0]     cur_thr;

	lcs_pix_if pix();
	lcs_res_if res();

	line_centroid_steering_top #(.MAX_WIDTH(MAX_WIDTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	lcs_steer_checker #(.MAX_WIDTH(MAX_WIDTH)) steer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pix),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : sink_side
		int unsigned hold;
		res.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (snk_stall && $urandom_range(0, 7) == 0) begin
				res.ready <= 1'b0;
				hold = $urandom_range(1, 17);
				repeat (hold) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
		input logic last);
		int unsigned gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			pix.valid <= 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.data <= '{blue: b, green: g, red: r, frame_end: last};
		do @(posedge clk); while (!pix.ready);
	endtask

	task automatic send_frame(input int unsigned flen, input int unsigned dark_pct);
		logic [7:0]  v;
		logic [7:0]  top_v;
		int unsigned pick;
		logic        last;
		top_v = (cur_thr > 8'd215) ? 8'hFF : cur_thr + 8'd40;
		for (int unsigned i = 0; i < flen; i++) begin
			pick = $urandom_range(0, 99);
			last = (i == flen - 1);
			if (pick < dark_pct) begin
				v = 8'($urandom_range(0, cur_thr));
				send_pixel(v, v, v, last);
			end else if (pick < dark_pct + 8) begin
				v = (cur_thr == 8'hFF) ? cur_thr : cur_thr + 8'd1;
				send_pixel(v, v, v, last);
			end else if (pick[0]) begin
				send_pixel(8'($urandom_range(0, top_v)), 8'($urandom_range(0, top_v)),
					8'($urandom_range(0, top_v)), last);
			end else begin
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), last);
			end
		end
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] thr,
		input logic [CFG_W-1:0] speed, input logic [CFG_W-1:0] gain);
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= fw;
		@(posedge clk);
		cfg_index <= REG_DARK_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_FORWARD_SPEED;
		cfg_data <= speed;
		@(posedge clk);
		cfg_index <= REG_STEER_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_thr = thr[THR_W-1:0];
	endtask

	initial begin : stimulus
		int unsigned      sent;
		int unsigned      phase_items;
		int unsigned      fw;
		int unsigned      flen;
		int unsigned      dark_pct;
		logic [CFG_W-1:0] fw_word;
		logic [CFG_W-1:0] thr_word;
		logic [CFG_W-1:0] speed_word;
		logic [CFG_W-1:0] gain_word;
		pix.valid <= 1'b0;
		pix.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		cur_thr = THR_RESET;
		src_idle = 1'b1;
		snk_stall = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty frame, single dark pixel, channel weights, grey at threshold
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd100, 8'd100, 8'd100, 1'b1);
		drain();

		// zero width acts as one column; full threshold and gain
		configure(16'hF800, 16'h5AFF, 16'hFFFF, 16'hFFFF);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd17, 8'd200, 8'd3, 1'b1);
		drain();

		// oversize width, stop mid-frame, then shrink width so the column wraps
		configure(16'h07FF, 16'h0000, 16'h0000, 16'hFFFF);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		drain();
		configure(16'd3, 16'd0, 16'd0, 16'hFFFF);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		drain();

		configure(16'd1025, 16'd128, 16'd1, 16'd0);
		send_pixel(8'd129, 8'd129, 8'd129, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		drain();

		configure(16'd2, 16'd127, 16'd40000, 16'd32768);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		drain();

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			src_idle = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			snk_stall = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: fw = 0;
				1: fw = 1;
				2: fw = 2;
				3: fw = $urandom_range(1000, 2047);
				default: fw = $urandom_range(3, 24);
			endcase
			fw_word = 16'($urandom);
			fw_word[FW_W-1:0] = 11'(fw);
			thr_word = 16'($urandom);
			case ($urandom_range(0, 4))
				0: thr_word[THR_W-1:0] = '0;
				1: thr_word[THR_W-1:0] = '1;
				default: ;
			endcase
			case ($urandom_range(0, 3))
				0: speed_word = '0;
				1: speed_word = '1;
				default: speed_word = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: gain_word = '0;
				1: gain_word = '1;
				default: gain_word = 16'($urandom);
			endcase
			configure(fw_word, thr_word, speed_word, gain_word);

			phase_items = 0;
			while (phase_items < 80 && sent < RANDOM_PIXELS) begin
				case ($urandom_range(0, 7))
					0: flen = 1;
					1: flen = $urandom_range(40, 200);
					default: flen = $urandom_range(2, 30);
				endcase
				if (flen > RANDOM_PIXELS - sent)
					flen = RANDOM_PIXELS - sent;
				case ($urandom_range(0, 5))
					0: dark_pct = 0;
					1: dark_pct = 92;
					default: dark_pct = $urandom_range(5, 60);
				endcase
				if (sent >= CALM_FROM) begin
					src_idle = 1'b0;
					snk_stall = 1'b0;
				end
				send_frame(flen, dark_pct);
				phase_items += flen;
				sent += flen;
			end
			drain();
		end

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/lcs_pkg.sv
rtl/lcs_if.sv
rtl/lcs_div.sv
rtl/line_centroid_steering_top.sv
bench/lcs_steer_checker.sv
bench/tb_line_centroid_steering_top.sv
